/* sv/tle_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tle_pkg
// Shared types and constants of the text literal escaper.
// ----------------------------------------------------------------------------
package tle_pkg;

    localparam int STORE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int CP_W        = 21;
    localparam int ESC_W       = 7;
    localparam int STEP_W      = 4;
    localparam int NDIG_W      = 3;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_PULL = 1'b1;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_BUSY = 2'd2;

    // register select is address bit 2
    localparam logic REG_PARENED = 1'b0;
    localparam logic REG_LIMIT   = 1'b1;

    localparam logic [8:0] LIMIT_RESET = 9'd50;

    localparam logic [CP_W-1:0] CH_TAB    = 21'h00009;
    localparam logic [CP_W-1:0] CH_NL     = 21'h0000A;
    localparam logic [CP_W-1:0] CH_RS     = 21'h0001E;
    localparam logic [CP_W-1:0] CH_SPACE  = 21'h00020;
    localparam logic [CP_W-1:0] CH_QUOTE  = 21'h00022;
    localparam logic [CP_W-1:0] CH_LPAREN = 21'h00028;
    localparam logic [CP_W-1:0] CH_RPAREN = 21'h00029;
    localparam logic [CP_W-1:0] CH_CARET  = 21'h0005E;
    localparam logic [CP_W-1:0] CH_LBRACE = 21'h0007B;
    localparam logic [CP_W-1:0] CH_RBRACE = 21'h0007D;
    localparam logic [CP_W-1:0] CH_DEL    = 21'h0007F;
    localparam logic [CP_W-1:0] CH_BOM    = 21'h0FEFF;

    localparam logic [ESC_W-1:0] ESC_TAB     = 7'h2D;
    localparam logic [ESC_W-1:0] ESC_NL      = 7'h2F;
    localparam logic [ESC_W-1:0] ESC_CTRL_OF = 7'h40;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        MODE_PLAIN,
        MODE_CARET,
        MODE_HEX
    } mode_t;

    typedef struct packed {
        mode_t             mode;
        logic [CP_W-1:0]   ch;
        logic [ESC_W-1:0]  second;
        logic [NDIG_W-1:0] ndig;
    } piece_t;

endpackage
`default_nettype wire

/* sv/tle_piece_gen.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tle_piece_gen
// Produces one output codepoint of a character's escape sequence per step.
// ----------------------------------------------------------------------------
module tle_piece_gen (
    input  var tle_pkg::piece_t              piece,
    input  var logic [tle_pkg::STEP_W-1:0]   step,
    output logic [tle_pkg::CP_W-1:0]         out_char,
    output logic                             last
);
    import tle_pkg::*;

    logic [STEP_W-1:0] len;
    logic [STEP_W-1:0] dig_idx;
    logic [3:0]        nibble;
    logic [CP_W-1:0]   digit;

    always_comb
    begin
        unique case (piece.mode)
            MODE_CARET: len = STEP_W'(2);
            MODE_HEX:   len = STEP_W'(piece.ndig) + STEP_W'(3);
            default:    len = STEP_W'(1);
        endcase
        last = (step == len - STEP_W'(1));
    end

    // hex digits run most significant first, from step 2
    assign dig_idx = STEP_W'(piece.ndig) + STEP_W'(1) - step;

    always_comb
    begin
        case (dig_idx[NDIG_W-1:0])
            3'd0:    nibble = piece.ch[3:0];
            3'd1:    nibble = piece.ch[7:4];
            3'd2:    nibble = piece.ch[11:8];
            3'd3:    nibble = piece.ch[15:12];
            3'd4:    nibble = piece.ch[19:16];
            3'd5:    nibble = {3'b000, piece.ch[20]};
            default: nibble = 4'h0;
        endcase
        if (nibble < 4'd10)
            digit = CP_W'(8'h30) + CP_W'(nibble);
        else
            digit = CP_W'(8'h37) + CP_W'(nibble);
    end

    always_comb
    begin
        unique case (piece.mode)
            MODE_CARET:
            begin
                if (step == STEP_W'(0))
                    out_char = CH_CARET;
                else
                    out_char = CP_W'(piece.second);
            end
            MODE_HEX:
            begin
                if (step == STEP_W'(0))
                    out_char = CH_CARET;
                else if (step == STEP_W'(1))
                    out_char = CH_LPAREN;
                else if (last)
                    out_char = CH_RPAREN;
                else
                    out_char = digit;
            end
            default:    out_char = piece.ch;
        endcase
    end

endmodule
`default_nettype wire

/* sv/text_literal_escaper.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// text_literal_escaper
// Stores a text and emits its escaped literal form one codepoint at a time.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. opcode LOAD stores
// codepoint and gives no result, or one status result when dropped; loads
// may follow back to back. opcode PULL gives the
// next piece of the literal: the first gives the opening delimiter, each
// later one gives the escape of one stored character (1 to 9 codepoints),
// and the one after the last character gives the closer and empties the store.
// Results appear on the cycle after the work that makes them, each for one
// cycle marked by result_valid; piece_last flags the last of a request.
// Delimiter pulls and dropped loads leave busy low. A character pull keeps
// busy high through the ST_READ state and then one emitted codepoint per
// cycle, and no new request is taken until it ends.
// The receiver cannot hold results off. Reset empties the store logically
// (counters only, no clearing pass) and sets parened_hex 0, quoted_limit 50.
// Registers: 0x0 parened_hex, 0x4 quoted_limit; write only while idle.
// ----------------------------------------------------------------------------
module text_literal_escaper (
    input  var logic                      clk,
    input  var logic                      rst_n,
    input  var logic                      start,
    output logic                          busy,
    input  var logic                      opcode,
    input  var logic [tle_pkg::CP_W-1:0]  codepoint,
    output logic                          result_valid,
    output logic [tle_pkg::CP_W-1:0]      out_char,
    output logic                          piece_last,
    output logic                          string_done,
    output logic [1:0]                    status,
    input  var logic                      psel,
    input  var logic                      penable,
    input  var logic                      pwrite,
    input  var logic [2:0]                paddr,
    input  var logic [31:0]               pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import tle_pkg::*;

    logic [CP_W-1:0] char_store [STORE_DEPTH];

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  char_count_reg, char_count_next;
    logic [CNT_W-1:0]  read_pointer_reg, read_pointer_next;
    logic [CNT_W-1:0]  open_braces_reg, open_braces_next;
    logic [CNT_W-1:0]  close_braces_reg, close_braces_next;
    logic              misaligned_reg, misaligned_next;
    logic              quote_seen_reg, quote_seen_next;
    logic [1:0]        newline_count_reg, newline_count_next;
    logic              emitting_reg, emitting_next;
    logic              braced_form_reg, braced_form_next;
    logic              parened_hex_reg;
    logic [8:0]        quoted_limit_reg;
    piece_t            piece_reg, piece_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CP_W-1:0]   rd_data_reg;

    logic              res_valid_reg, res_valid_next;
    logic [CP_W-1:0]   res_char_reg, res_char_next;
    logic              res_last_reg, res_last_next;
    logic              res_done_reg, res_done_next;
    logic [1:0]        res_status_reg, res_status_next;

    logic              accept;
    logic              wr_en;
    logic              rd_en;
    logic              cfg_wr;
    logic [CP_W-1:0]   gen_char;
    logic              gen_last;
    logic              quoted_ok;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb
    begin
        if (paddr[2] == REG_LIMIT)
            prdata = {23'd0, quoted_limit_reg};
        else
            prdata = {31'd0, parened_hex_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parened_hex_reg  <= 1'b0;
            quoted_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_LIMIT)
                quoted_limit_reg <= pwdata[8:0];
            else
                parened_hex_reg <= pwdata[0];
        end
    end

    // Store: loads are refused while emitting, so a read never meets a write.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            char_store[char_count_reg[ADDR_W-1:0]] <= codepoint;
        if (rd_en)
            rd_data_reg <= char_store[read_pointer_reg[ADDR_W-1:0]];
    end

    // Escape classification of the character just read.
    always_comb
    begin
        piece_next.ch     = rd_data_reg;
        piece_next.mode   = MODE_PLAIN;
        piece_next.second = rd_data_reg[ESC_W-1:0];
        if (rd_data_reg[20])
            piece_next.ndig = NDIG_W'(6);
        else if (|rd_data_reg[19:16])
            piece_next.ndig = NDIG_W'(5);
        else if (|rd_data_reg[15:12])
            piece_next.ndig = NDIG_W'(4);
        else if (|rd_data_reg[11:8])
            piece_next.ndig = NDIG_W'(3);
        else if (|rd_data_reg[7:4])
            piece_next.ndig = NDIG_W'(2);
        else
            piece_next.ndig = NDIG_W'(1);

        if (braced_form_reg && (rd_data_reg == CH_LBRACE || rd_data_reg == CH_RBRACE))
        begin
            if (misaligned_reg)
                piece_next.mode = MODE_CARET;
        end
        else if (braced_form_reg && (rd_data_reg == CH_NL || rd_data_reg == CH_QUOTE))
        begin
            piece_next.mode = MODE_PLAIN;
        end
        else if (rd_data_reg >= CH_DEL || rd_data_reg == CH_RS)
        begin
            // BOM is above DEL, so it lands here too
            if (parened_hex_reg || rd_data_reg == CH_RS || rd_data_reg == CH_BOM)
                piece_next.mode = MODE_HEX;
        end
        else if (rd_data_reg < CH_SPACE)
        begin
            piece_next.mode = MODE_CARET;
            if (rd_data_reg == CH_TAB)
                piece_next.second = ESC_TAB;
            else if (rd_data_reg == CH_NL)
                piece_next.second = ESC_NL;
            else
                piece_next.second = rd_data_reg[ESC_W-1:0] + ESC_CTRL_OF;
        end
        else if (rd_data_reg == CH_QUOTE || rd_data_reg == CH_CARET)
        begin
            piece_next.mode = MODE_CARET;
        end
    end

    tle_piece_gen u_piece_gen (
        .piece    (piece_reg),
        .step     (step_reg),
        .out_char (gen_char),
        .last     (gen_last)
    );

    assign quoted_ok = (char_count_reg <= CNT_W'(quoted_limit_reg)) && !quote_seen_reg
                       && (newline_count_reg != 2'd3);

    always_comb
    begin
        state_next         = state_reg;
        char_count_next    = char_count_reg;
        read_pointer_next  = read_pointer_reg;
        open_braces_next   = open_braces_reg;
        close_braces_next  = close_braces_reg;
        misaligned_next    = misaligned_reg;
        quote_seen_next    = quote_seen_reg;
        newline_count_next = newline_count_reg;
        emitting_next      = emitting_reg;
        braced_form_next   = braced_form_reg;
        step_next          = step_reg;
        wr_en              = 1'b0;
        rd_en              = 1'b0;
        res_valid_next     = 1'b0;
        res_char_next      = res_char_reg;
        res_last_next      = res_last_reg;
        res_done_next      = 1'b0;
        res_status_next    = STATUS_OK;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && opcode == OP_LOAD)
                begin
                    if (emitting_reg || char_count_reg >= CNT_W'(STORE_DEPTH))
                    begin
                        res_valid_next  = 1'b1;
                        res_char_next   = '0;
                        res_last_next   = 1'b1;
                        res_status_next = emitting_reg ? STATUS_BUSY : STATUS_FULL;
                    end
                    else
                    begin
                        wr_en           = 1'b1;
                        char_count_next = char_count_reg + CNT_W'(1);
                        if (codepoint == CH_LBRACE)
                            open_braces_next = open_braces_reg + CNT_W'(1);
                        else if (codepoint == CH_RBRACE)
                        begin
                            close_braces_next = close_braces_reg + CNT_W'(1);
                            if (close_braces_reg >= open_braces_reg)
                                misaligned_next = 1'b1;
                        end
                        else if (codepoint == CH_QUOTE)
                            quote_seen_next = 1'b1;
                        else if (codepoint == CH_NL && newline_count_reg != 2'd3)
                            newline_count_next = newline_count_reg + 2'd1;
                    end
                end
                else if (accept)
                begin
                    if (!emitting_reg)
                    begin
                        emitting_next    = 1'b1;
                        braced_form_next = !quoted_ok;
                        if (open_braces_reg != close_braces_reg)
                            misaligned_next = 1'b1;
                        res_valid_next = 1'b1;
                        res_char_next  = quoted_ok ? CH_QUOTE : CH_LBRACE;
                        res_last_next  = 1'b1;
                    end
                    else if (read_pointer_reg < char_count_reg)
                    begin
                        rd_en             = 1'b1;
                        read_pointer_next = read_pointer_reg + CNT_W'(1);
                        state_next        = ST_READ;
                    end
                    else
                    begin
                        res_valid_next     = 1'b1;
                        res_char_next      = braced_form_reg ? CH_RBRACE : CH_QUOTE;
                        res_last_next      = 1'b1;
                        res_done_next      = 1'b1;
                        char_count_next    = '0;
                        read_pointer_next  = '0;
                        open_braces_next   = '0;
                        close_braces_next  = '0;
                        misaligned_next    = 1'b0;
                        quote_seen_next    = 1'b0;
                        newline_count_next = 2'd0;
                        emitting_next      = 1'b0;
                        braced_form_next   = 1'b0;
                    end
                end
            end
            ST_READ:
            begin
                step_next  = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                res_valid_next = 1'b1;
                res_char_next  = gen_char;
                res_last_next  = gen_last;
                step_next      = step_reg + STEP_W'(1);
                if (gen_last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            char_count_reg    <= '0;
            read_pointer_reg  <= '0;
            open_braces_reg   <= '0;
            close_braces_reg  <= '0;
            misaligned_reg    <= 1'b0;
            quote_seen_reg    <= 1'b0;
            newline_count_reg <= 2'd0;
            emitting_reg      <= 1'b0;
            braced_form_reg   <= 1'b0;
            step_reg          <= '0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            char_count_reg    <= char_count_next;
            read_pointer_reg  <= read_pointer_next;
            open_braces_reg   <= open_braces_next;
            close_braces_reg  <= close_braces_next;
            misaligned_reg    <= misaligned_next;
            quote_seen_reg    <= quote_seen_next;
            newline_count_reg <= newline_count_next;
            emitting_reg      <= emitting_next;
            braced_form_reg   <= braced_form_next;
            step_reg          <= step_next;
            res_valid_reg     <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
            piece_reg <= piece_next;
        res_char_reg   <= res_char_next;
        res_last_reg   <= res_last_next;
        res_done_reg   <= res_done_next;
        res_status_reg <= res_status_next;
    end

    assign result_valid = res_valid_reg;
    assign out_char     = res_char_reg;
    assign piece_last   = res_last_reg;
    assign string_done  = res_done_reg;
    assign status       = res_status_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        read_pointer_reg <= char_count_reg)
        else $error("read pointer beyond stored count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        char_count_reg <= CNT_W'(STORE_DEPTH))
        else $error("character count beyond store depth");

    a_read_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |=> state_reg == ST_EMIT && emitting_reg)
        else $error("store read not followed by emission");

    a_drop_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != STATUS_OK |-> piece_last && !string_done)
        else $error("dropped load result malformed");

    a_busy_only_emitting: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> emitting_reg)
        else $error("busy outside emitting phase");

endmodule
`default_nettype wire
